/* hdl/mhpq_pkg.sv */
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants for the max-heap priority queue: field widths,
// command and status codes, the stored entry, and the command/status bundles
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

  localparam int KEY_W = 32;
  localparam int TAG_W = 16;
  localparam int OCC_W = 6;

  typedef enum logic {
    CMD_INSERT  = 1'b0,
    CMD_EXTRACT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_EXTRACTED = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // read address selection
  typedef enum logic [1:0] {
    RD_UP = 2'd0,  // parent of pos
    RD_EX = 2'd1,  // root and last entry
    RD_DN = 2'd2   // both children of pos
  } rd_mode_t;

  // write data selection
  typedef enum logic [1:0] {
    WR_ENTRY = 2'd0,  // the entry being sifted
    WR_A     = 2'd1,  // read port A data
    WR_B     = 2'd2   // read port B data
  } wr_src_t;

  typedef enum logic [1:0] {
    POS_HOLD   = 2'd0,
    POS_PARENT = 2'd1,
    POS_LEFT   = 2'd2,
    POS_RIGHT  = 2'd3
  } pos_sel_t;

  typedef enum logic [2:0] {
    S_IDLE    = 3'd0,
    S_UP_READ = 3'd1,
    S_UP_CMP  = 3'd2,
    S_EX_READ = 3'd3,
    S_EX_LOAD = 3'd4,
    S_DN_READ = 3'd5,
    S_DN_CMP  = 3'd6,
    S_FINISH  = 3'd7
  } state_t;

  typedef struct packed {
    logic     capture;
    logic     rd_en;
    rd_mode_t rd_mode;
    logic     load_ext;
    logic     wr_en;
    wr_src_t  wr_src;
    pos_sel_t pos_sel;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic up_swap;
    logic dn_left;
    logic dn_right;
  } dp_stat_t;

endpackage

`default_nettype wire

/* hdl/mhpq_in_if.sv */
// ----------------------------------------------------------------------------
// mhpq_in_if
// Request channel: one insert or extract command per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mhpq_in_if import mhpq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [KEY_W-1:0] item_key;
  logic [TAG_W-1:0] item_tag;

  modport source (output valid, command, item_key, item_tag, input ready);
  modport sink   (input valid, command, item_key, item_tag, output ready);
endinterface

`default_nettype wire

/* hdl/mhpq_out_if.sv */
// ----------------------------------------------------------------------------
// mhpq_out_if
// Response channel: one result per accepted command.
// ----------------------------------------------------------------------------
`default_nettype none

interface mhpq_out_if import mhpq_pkg::*; ();
  logic             valid;
  logic             ready;
  status_t          status;
  logic [KEY_W-1:0] out_key;
  logic [TAG_W-1:0] out_tag;
  logic [OCC_W-1:0] occupancy;

  modport source (output valid, status, out_key, out_tag, occupancy, input ready);
  modport sink   (input valid, status, out_key, out_tag, occupancy, output ready);
endinterface

`default_nettype wire

/* hdl/max_heap_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// max_heap_priority_queue_unit
// Binary max-heap priority queue of CAPACITY key/tag entries.
// ----------------------------------------------------------------------------
// One command at a time. An insert places the new entry in the first free slot
// and climbs: each level reads the parent, then either pulls it down and moves
// up or writes the entry. An extract reads the root and the last entry,
// returns the root and, unless the heap is now empty, sifts the last entry
// down from the root, each level reading both children and then writing
// the larger child up or the entry. Refused commands (extract on empty,
// insert on full) go straight to the result. A result waits while the
// previous one is stalled. The entry memory has one write port and registered
// reads, so each tree level costs a read state and a compare/write state.
// The result register lets a new command transfer while the previous result
// waits. Memory contents are not cleared at reset; child reads past the
// count are masked out of the sift-down compares.
// ----------------------------------------------------------------------------
`default_nettype none

module max_heap_priority_queue_unit import mhpq_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  mhpq_in_if.sink    req,
  mhpq_out_if.source rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mhpq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_command (req.command),
    .out_ready  (rsp.ready),
    .stat       (stat),
    .in_ready   (req.ready),
    .out_valid  (rsp.valid),
    .cmd        (cmd)
  );

  mhpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .command   (req.command),
    .item_key  (req.item_key),
    .item_tag  (req.item_tag),
    .stat      (stat),
    .status    (rsp.status),
    .out_key   (rsp.out_key),
    .out_tag   (rsp.out_tag),
    .occupancy (rsp.occupancy)
  );

endmodule

`default_nettype wire

/* hdl/mhpq_dp.sv */
// ----------------------------------------------------------------------------
// mhpq_dp
// Heap datapath: entry memory with one write and two registered read ports,
// the sifting entry, position and count registers, comparators, and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_dp import mhpq_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire dp_cmd_t          cmd,
  input  wire logic             command,
  input  wire logic [KEY_W-1:0] item_key,
  input  wire logic [TAG_W-1:0] item_tag,
  output dp_stat_t              stat,
  output status_t               status,
  output logic      [KEY_W-1:0] out_key,
  output logic      [TAG_W-1:0] out_tag,
  output logic      [OCC_W-1:0] occupancy
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;

  entry_t mem [CAPACITY];

  logic [CW-1:0] count;
  logic [AW-1:0] pos;
  entry_t        ent;
  entry_t        top;
  status_t       op_status;
  entry_t        rd_a;
  entry_t        rd_b;

  logic [AW-1:0]    pos_parent;
  logic [IW-1:0]    left_idx;
  logic [IW-1:0]    right_idx;
  logic [IW-1:0]    count_ext;
  logic [AW-1:0]    addr_a;
  logic [AW-1:0]    addr_b;
  logic [KEY_W-1:0] best_key;
  entry_t           wr_data;

  assign pos_parent = (pos - AW'(1)) >> 1;
  assign left_idx   = {1'b0, pos, 1'b1};
  assign right_idx  = left_idx + IW'(1);
  assign count_ext  = IW'(count);

  assign stat.full     = (count == CW'(CAPACITY));
  assign stat.empty    = (count == '0);
  assign stat.at_root  = (pos == '0);
  assign stat.up_swap  = (rd_a.key < ent.key);
  assign stat.dn_left  = (left_idx < count_ext) && (rd_a.key > ent.key);
  assign best_key      = stat.dn_left ? rd_a.key : ent.key;
  assign stat.dn_right = (right_idx < count_ext) && (rd_b.key > best_key);

  always_comb begin
    unique case (cmd.rd_mode)
      RD_UP: begin
        addr_a = pos_parent;
        addr_b = pos_parent;
      end
      RD_EX: begin
        addr_a = '0;
        addr_b = count[AW-1:0];
      end
      RD_DN: begin
        addr_a = left_idx[AW-1:0];
        addr_b = right_idx[AW-1:0];
      end
      default: begin
        addr_a = '0;
        addr_b = '0;
      end
    endcase
  end

  always_comb begin
    unique case (cmd.wr_src)
      WR_A:    wr_data = rd_a;
      WR_B:    wr_data = rd_b;
      default: wr_data = ent;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[pos] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.capture) begin
      if (command == CMD_INSERT) begin
        if (!stat.full) begin
          count <= count + CW'(1);
        end
      end else if (!stat.empty) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ent <= '{key: item_key, tag: item_tag};
      top <= '0;
      if (command == CMD_INSERT) begin
        op_status <= stat.full ? ST_FULL : ST_INSERTED;
        // new entry starts in the first free slot
        pos       <= count[AW-1:0];
      end else begin
        op_status <= stat.empty ? ST_EMPTY : ST_EXTRACTED;
      end
    end else if (cmd.load_ext) begin
      // return the root, sift the last entry down from the root
      top <= rd_a;
      ent <= rd_b;
      pos <= '0;
    end else begin
      case (cmd.pos_sel)
        POS_PARENT: pos <= pos_parent;
        POS_LEFT:   pos <= left_idx[AW-1:0];
        POS_RIGHT:  pos <= right_idx[AW-1:0];
        default:    pos <= pos;
      endcase
    end

    if (cmd.load_out) begin
      status    <= op_status;
      out_key   <= top.key;
      out_tag   <= top.tag;
      occupancy <= OCC_W'(count);
    end
  end

endmodule

`default_nettype wire

/* hdl/mhpq_ctrl.sv */
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Sequencer for insert (sift up) and extract (sift down), plus the output
// valid flag and the request ready.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_ctrl import mhpq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     in_command,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output logic          in_ready,
  output logic          out_valid,
  output dp_cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_command == CMD_EXTRACT) begin
            state_next = stat.empty ? S_FINISH : S_EX_READ;
          end else begin
            state_next = stat.full ? S_FINISH : S_UP_READ;
          end
        end
      end

      S_UP_READ: begin
        if (stat.at_root) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_src = WR_ENTRY;
          state_next = S_FINISH;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_mode = RD_UP;
          state_next  = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        cmd.wr_en = 1'b1;
        if (stat.up_swap) begin
          // pull the parent down, climb one level
          cmd.wr_src  = WR_A;
          cmd.pos_sel = POS_PARENT;
          state_next  = S_UP_READ;
        end else begin
          cmd.wr_src = WR_ENTRY;
          state_next = S_FINISH;
        end
      end

      S_EX_READ: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_mode = RD_EX;
        state_next  = S_EX_LOAD;
      end

      S_EX_LOAD: begin
        cmd.load_ext = 1'b1;
        state_next   = stat.empty ? S_FINISH : S_DN_READ;
      end

      S_DN_READ: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_mode = RD_DN;
        state_next  = S_DN_CMP;
      end

      S_DN_CMP: begin
        cmd.wr_en = 1'b1;
        if (stat.dn_right) begin
          cmd.wr_src  = WR_B;
          cmd.pos_sel = POS_RIGHT;
          state_next  = S_DN_READ;
        end else if (stat.dn_left) begin
          cmd.wr_src  = WR_A;
          cmd.pos_sel = POS_LEFT;
          state_next  = S_DN_READ;
        end else begin
          cmd.wr_src = WR_ENTRY;
          state_next = S_FINISH;
        end
      end

      S_FINISH: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/mhpq_checker.sv */
// ----------------------------------------------------------------------------
// mhpq_checker
// Port-level checks on the result channel of the priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_checker import mhpq_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             rsp_valid,
  input wire logic             rsp_ready,
  input wire status_t          status,
  input wire logic [KEY_W-1:0] out_key,
  input wire logic [TAG_W-1:0] out_tag,
  input wire logic [OCC_W-1:0] occupancy
);

  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(CAPACITY);

  // only an extract carries a key and a tag
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_EXTRACTED) |-> (out_key == '0) && (out_tag == '0))
    else $error("non-extract result carries a key or tag");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_EMPTY) |-> (occupancy == '0))
    else $error("extract refused while heap not empty");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_FULL) |-> (occupancy == FULL_OCC))
    else $error("insert refused while heap not full");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(out_key)
      && $stable(out_tag) && $stable(occupancy))
    else $error("stalled result changed");

endmodule

bind max_heap_priority_queue_unit mhpq_checker #(
  .CAPACITY (CAPACITY)
) u_mhpq_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .out_key   (rsp.out_key),
  .out_tag   (rsp.out_tag),
  .occupancy (rsp.occupancy)
);

`default_nettype wire
